// ===== rtl/core/tkm_pkg.sv =====
// ----------------------------------------------------------------------------
// tkm_pkg
// Shared types and constants of the top-k sorted list merge unit.
// ----------------------------------------------------------------------------
package tkm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int ID_W   = 63;
  localparam int DIST_W = 32;

  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_LOAD_SRC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_TGT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MERGE    = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENDING  = 2'd1;

  localparam int KEEP_W = 6;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [DIST_W-1:0] distance;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // role of a list bank: source, target or spare (merge scratch)
  typedef logic [1:0] bank_sel_t;
  localparam int NUM_BANKS = 3;

  typedef struct packed {
    logic src_done;
    logic tgt_done;
    logic ascending;
  } pick_ctl_t;

endpackage

// ===== rtl/core/topk_sorted_list_merge_unit.sv =====
// ----------------------------------------------------------------------------
// topk_sorted_list_merge_unit
// Holds a source and a target list of (id, distance) pairs and merges them.
// ----------------------------------------------------------------------------
// Load items (source or target) can arrive back to back. A merge item
// occupies the block until its last result item is taken: each result item
// passes through RAM read, compare/select and output, plus any wait on
// out_ready; an empty result goes straight to output. The steps are set by
// the single compare unit and the registered read port of the three list
// RAMs. The lists live in three banks whose roles (source, target, merge
// scratch) rotate, so a merge never copies a list. Loads into a full list
// are dropped and flagged.
module topk_sorted_list_merge_unit
  import tkm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACTION_W-1:0]      action,
  input  logic [ID_W-1:0]          entry_id,
  input  logic signed [DIST_W-1:0] entry_distance,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ID_W-1:0]          out_id,
  output logic signed [DIST_W-1:0] out_distance,
  output logic                     last,
  output logic                     list_empty,
  output logic                     overflowed,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_PICK  = 4'b0100,
    S_SEND  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [KEEP_W-1:0] keep_count;
  logic              ascending;
  logic [CNT_W-1:0]  src_fill;
  logic [CNT_W-1:0]  tgt_count;
  logic              overflow_flag;
  logic              ovf_item;
  bank_sel_t         src_sel;
  bank_sel_t         tgt_sel;
  bank_sel_t         spr_sel;

  logic [CNT_W-1:0]  si;
  logic [CNT_W-1:0]  ti;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  src_len;
  logic [CNT_W-1:0]  lim;
  logic              merge_mode;
  logic              last_pick;

  logic [CNT_W-1:0]  keep_lim;
  logic              in_fire;
  logic              merge_fire;
  logic              src_full;
  logic              tgt_full;

  entry_t            rd_data [NUM_BANKS];
  entry_t            src_entry;
  entry_t            tgt_entry;
  entry_t            chosen;
  entry_t            load_entry;
  logic              use_tgt;
  pick_ctl_t         pick_ctl;

  logic [CNT_W-1:0]  si_inc;
  logic [CNT_W-1:0]  ti_inc;
  logic [CNT_W-1:0]  n_inc;
  logic              pick_last;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = (state == S_SEND);
  assign overflowed = ovf_item;

  assign in_fire    = in_valid && in_ready;
  assign merge_fire = in_fire && (action == ACT_MERGE);
  assign src_full   = (src_fill == CNT_W'(LIST_DEPTH));
  assign tgt_full   = (tgt_count == CNT_W'(LIST_DEPTH));
  assign load_entry = '{id: entry_id, distance: entry_distance};

  // zero acts as one, anything past the depth acts as the depth
  always_comb begin
    priority if (keep_count == '0) begin
      keep_lim = CNT_W'(1);
    end else if (int'(keep_count) > LIST_DEPTH) begin
      keep_lim = CNT_W'(LIST_DEPTH);
    end else begin
      keep_lim = CNT_W'(keep_count);
    end
  end

  // list banks
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;

    always_comb begin
      we    = 1'b0;
      waddr = n[ADDR_W-1:0];
      wdata = chosen;
      if (state == S_IDLE && in_valid) begin
        if (action == ACT_LOAD_SRC && src_sel == bank_sel_t'(b) && !src_full) begin
          we    = 1'b1;
          waddr = src_fill[ADDR_W-1:0];
          wdata = load_entry;
        end else if (action == ACT_LOAD_TGT && tgt_sel == bank_sel_t'(b) && !tgt_full) begin
          we    = 1'b1;
          waddr = tgt_count[ADDR_W-1:0];
          wdata = load_entry;
        end
      end else if (state == S_PICK && merge_mode && spr_sel == bank_sel_t'(b)) begin
        we = 1'b1;
      end
    end

    assign raddr = (src_sel == bank_sel_t'(b)) ? si[ADDR_W-1:0] : ti[ADDR_W-1:0];

    tkm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(LIST_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rd_data[b])
    );
  end

  always_comb begin
    unique case (src_sel)
      2'd0:    src_entry = rd_data[0];
      2'd1:    src_entry = rd_data[1];
      default: src_entry = rd_data[2];
    endcase
    unique case (tgt_sel)
      2'd0:    tgt_entry = rd_data[0];
      2'd1:    tgt_entry = rd_data[1];
      default: tgt_entry = rd_data[2];
    endcase
  end

  assign pick_ctl = '{src_done: (si >= src_len), tgt_done: (ti >= tgt_count),
                      ascending: ascending};

  tkm_pick u_pick (
    .ctl      (pick_ctl),
    .src_entry(src_entry),
    .tgt_entry(tgt_entry),
    .use_tgt  (use_tgt),
    .chosen   (chosen)
  );

  assign si_inc    = si + {{(CNT_W-1){1'b0}}, ~use_tgt};
  assign ti_inc    = ti + {{(CNT_W-1){1'b0}}, use_tgt};
  assign n_inc     = n + CNT_W'(1);
  assign pick_last = (n_inc == lim) || ((si_inc == src_len) && (ti_inc == tgt_count));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (merge_fire) begin
          state_next = (src_fill == '0 && tgt_count == '0) ? S_SEND : S_FETCH;
        end
      end
      S_FETCH: state_next = S_PICK;
      S_PICK:  state_next = S_SEND;
      S_SEND: begin
        if (out_ready) begin
          state_next = last_pick ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      keep_count    <= KEEP_RESET;
      ascending     <= 1'b1;
      src_fill      <= '0;
      tgt_count     <= '0;
      overflow_flag <= 1'b0;
      ovf_item      <= 1'b0;
      src_sel       <= 2'd0;
      tgt_sel       <= 2'd1;
      spr_sel       <= 2'd2;
      si            <= '0;
      ti            <= '0;
      n             <= '0;
      src_len       <= '0;
      lim           <= '0;
      merge_mode    <= 1'b0;
      last_pick     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEEP_COUNT) begin
          keep_count <= cfg_data[KEEP_W-1:0];
        end else if (cfg_index == REG_ASCENDING) begin
          ascending <= cfg_data[0];
        end
      end

      if (in_fire) begin
        if (action == ACT_LOAD_SRC) begin
          if (src_full) begin
            overflow_flag <= 1'b1;
          end else begin
            src_fill <= src_fill + CNT_W'(1);
          end
        end else if (action == ACT_LOAD_TGT) begin
          if (tgt_full) begin
            overflow_flag <= 1'b1;
          end else begin
            tgt_count <= tgt_count + CNT_W'(1);
          end
        end else if (action == ACT_MERGE) begin
          ovf_item      <= overflow_flag;
          overflow_flag <= 1'b0;
          si            <= '0;
          ti            <= '0;
          n             <= '0;
          priority if (src_fill == '0) begin
            // target goes out unchanged, or one empty item
            src_len    <= '0;
            lim        <= CNT_W'(LIST_DEPTH);
            merge_mode <= 1'b0;
            last_pick  <= (tgt_count == '0);
          end else if (tgt_count == '0) begin
            // source becomes the target as it is
            src_sel    <= tgt_sel;
            tgt_sel    <= src_sel;
            tgt_count  <= src_fill;
            src_fill   <= '0;
            src_len    <= '0;
            lim        <= CNT_W'(LIST_DEPTH);
            merge_mode <= 1'b0;
            last_pick  <= 1'b0;
          end else begin
            src_len    <= src_fill;
            lim        <= keep_lim;
            merge_mode <= 1'b1;
            last_pick  <= 1'b0;
          end
        end
      end

      if (state == S_PICK) begin
        si        <= si_inc;
        ti        <= ti_inc;
        n         <= n_inc;
        last_pick <= pick_last;
        if (merge_mode && pick_last) begin
          // merged list in the scratch bank becomes the target
          tgt_sel   <= spr_sel;
          spr_sel   <= tgt_sel;
          tgt_count <= n_inc;
          src_fill  <= '0;
        end
      end
    end
  end

  // result item register
  always_ff @(posedge clk) begin
    if (merge_fire) begin
      out_id       <= '0;
      out_distance <= '0;
      last         <= 1'b1;
      list_empty   <= 1'b1;
    end else if (state == S_PICK) begin
      out_id       <= chosen.id;
      out_distance <= chosen.distance;
      last         <= pick_last;
      list_empty   <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/tkm_ram.sv =====
// ----------------------------------------------------------------------------
// tkm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tkm_pick.sv =====
// ----------------------------------------------------------------------------
// tkm_pick
// Shared compare and select unit: picks the next entry of a two-way merge.
// ----------------------------------------------------------------------------
module tkm_pick
  import tkm_pkg::*;
(
  input  pick_ctl_t ctl,
  input  entry_t    src_entry,
  input  entry_t    tgt_entry,
  output logic      use_tgt,
  output entry_t    chosen
);

  logic src_gt;
  logic src_lt;

  assign src_gt = src_entry.distance > tgt_entry.distance;
  assign src_lt = src_entry.distance < tgt_entry.distance;

  always_comb begin
    // ties go to the source entry
    priority if (ctl.src_done) begin
      use_tgt = 1'b1;
    end else if (ctl.tgt_done) begin
      use_tgt = 1'b0;
    end else begin
      use_tgt = ctl.ascending ? src_gt : src_lt;
    end
  end

  assign chosen = use_tgt ? tgt_entry : src_entry;

endmodule

// ===== rtl/core/tkm_chk.sv =====
// ----------------------------------------------------------------------------
// tkm_chk
// Port-level checks of the top-k sorted list merge unit, bound to the top.
// ----------------------------------------------------------------------------
module tkm_chk
  import tkm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [ACTION_W-1:0]      action,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ID_W-1:0]          out_id,
  input logic signed [DIST_W-1:0] out_distance,
  input logic                     last,
  input logic                     list_empty,
  input logic                     overflowed
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_distance)
                                && $stable(last) && $stable(list_empty))
    else $error("result item changed while stalled");

  // no new item is taken while a merge is emitting
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during merge output");

  // an empty result is a single item
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_empty |-> last)
    else $error("empty result item not marked last");

  // loads produce no result items
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action != ACT_MERGE |=> !out_valid)
    else $error("result item after a load");

  // overflow report stays fixed across one merge
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> $stable(overflowed))
    else $error("overflow flag changed within a merge");

endmodule

bind topk_sorted_list_merge_unit tkm_chk u_tkm_chk (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the top-k sorted list merge unit.
// Loads random, mostly distance-ordered source and target lists, merges them
// under several keep counts and both orders, and checks every merged item
// against an in-bench predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tkm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int QUIET_CYCLES = 16;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 6;
  localparam int NUM_PHASES   = 6;

  typedef logic signed [DIST_W-1:0] dist_q_t[$];

  typedef struct {
    logic [ID_W-1:0]          id;
    logic signed [DIST_W-1:0] distance;
    logic                     last;
    logic                     empty;
    logic                     ovf;
  } merged_item_t;

  class merge_scoreboard;
    logic [ID_W-1:0]          src_id[LIST_DEPTH];
    logic signed [DIST_W-1:0] src_dist[LIST_DEPTH];
    logic [ID_W-1:0]          tgt_id[LIST_DEPTH];
    logic signed [DIST_W-1:0] tgt_dist[LIST_DEPTH];
    int                       src_n;
    int                       tgt_n;
    int                       keep;
    bit                       asc;
    bit                       dropped;
    int                       errors;
    merged_item_t             awaited[$];

    function new();
      src_n   = 0;
      tgt_n   = 0;
      keep    = int'(KEEP_RESET);
      asc     = 1'b1;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_KEEP_COUNT) keep = int'(data);
      else if (idx == REG_ASCENDING) asc = data[0];
    endfunction

    function void merge_lists();
      logic [ID_W-1:0]          m_id[LIST_DEPTH];
      logic signed [DIST_W-1:0] m_dist[LIST_DEPTH];
      int                       lim;
      int                       n;
      int                       si;
      int                       ti;
      bit                       take_tgt;
      if (src_n == 0) return;
      // empty target takes the source whole, no truncation
      if (tgt_n == 0) begin
        tgt_id   = src_id;
        tgt_dist = src_dist;
        tgt_n    = src_n;
        src_n    = 0;
        return;
      end
      lim = keep;
      if (lim < 1) lim = 1;
      if (lim > LIST_DEPTH) lim = LIST_DEPTH;
      n  = 0;
      si = 0;
      ti = 0;
      while (n < lim && (si < src_n || ti < tgt_n)) begin
        if (si >= src_n) take_tgt = 1'b1;
        else if (ti >= tgt_n) take_tgt = 1'b0;
        else take_tgt = asc ? (src_dist[si] > tgt_dist[ti]) : (src_dist[si] < tgt_dist[ti]);
        if (take_tgt) begin
          m_id[n]   = tgt_id[ti];
          m_dist[n] = tgt_dist[ti];
          ti++;
        end else begin
          m_id[n]   = src_id[si];
          m_dist[n] = src_dist[si];
          si++;
        end
        n++;
      end
      tgt_id   = m_id;
      tgt_dist = m_dist;
      tgt_n    = n;
      src_n    = 0;
    endfunction

    function void note_input(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                             logic signed [DIST_W-1:0] distance);
      merged_item_t it;
      case (act)
        ACT_LOAD_SRC: begin
          if (src_n < LIST_DEPTH) begin
            src_id[src_n]   = id;
            src_dist[src_n] = distance;
            src_n++;
          end else begin
            dropped = 1'b1;
          end
        end
        ACT_LOAD_TGT: begin
          if (tgt_n < LIST_DEPTH) begin
            tgt_id[tgt_n]   = id;
            tgt_dist[tgt_n] = distance;
            tgt_n++;
          end else begin
            dropped = 1'b1;
          end
        end
        ACT_MERGE: begin
          merge_lists();
          it.ovf = dropped;
          dropped = 1'b0;
          if (tgt_n == 0) begin
            it.id       = '0;
            it.distance = '0;
            it.last     = 1'b1;
            it.empty    = 1'b1;
            awaited.insert(awaited.size(), it);
          end else begin
            for (int k = 0; k < tgt_n; k++) begin
              it.id       = tgt_id[k];
              it.distance = tgt_dist[k];
              it.last     = (k + 1 == tgt_n);
              it.empty    = 1'b0;
              awaited.insert(awaited.size(), it);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [ID_W-1:0] id, logic signed [DIST_W-1:0] distance,
                      logic lst, logic empty, logic ovf);
      merged_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("item id=%h dist=%h arrived with nothing awaited", id, distance));
        return;
      end
      want = awaited.pop_front();
      if (id !== want.id || distance !== want.distance || lst !== want.last ||
          empty !== want.empty || ovf !== want.ovf)
        report($sformatf("got id=%h dist=%h last=%b empty=%b ovf=%b, want %h %h %b %b %b",
                         id, distance, lst, empty, ovf,
                         want.id, want.distance, want.last, want.empty, want.ovf));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACTION_W-1:0]      action;
  logic [ID_W-1:0]          entry_id;
  logic signed [DIST_W-1:0] entry_distance;
  logic                     out_valid;
  logic                     out_ready;
  logic [ID_W-1:0]          out_id;
  logic signed [DIST_W-1:0] out_distance;
  logic                     last;
  logic                     list_empty;
  logic                     overflowed;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  merge_scoreboard sb;
  bit              no_idle;
  bit              cur_asc;
  bit              result_taken;
  int              results_seen;
  int              items_sent;
  int              cycle_count;

  topk_sorted_list_merge_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .entry_id       (entry_id),
    .entry_distance (entry_distance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_id         (out_id),
    .out_distance   (out_distance),
    .last           (last),
    .list_empty     (list_empty),
    .overflowed     (overflowed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // handshake monitor, samples pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(action, entry_id, entry_distance);
      if (out_valid && out_ready) begin
        sb.check_result(out_id, out_distance, last, list_empty, overflowed);
        results_seen++;
        result_taken = 1'b1;
      end
    end
  end

  // result side: random stall after each item, one long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (result_taken) begin
        result_taken = 1'b0;
        if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
        else stall = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: raw = '0;
      1: raw = '1;
      default: ;
    endcase
    return raw[ID_W-1:0];
  endfunction

  // bias toward ties and the signed extremes
  function automatic logic signed [DIST_W-1:0] pick_distance();
    logic signed [DIST_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic dist_q_t sorted_dists(int n, bit asc, bit ordered);
    dist_q_t                  q;
    logic signed [DIST_W-1:0] v;
    int                       pos;
    for (int k = 0; k < n; k++) begin
      v = pick_distance();
      pos = q.size();
      if (ordered)
        for (int m = q.size() - 1; m >= 0; m--)
          if (asc ? (q[m] > v) : (q[m] < v)) pos = m;
      q.insert(pos, v);
    end
    return q;
  endfunction

  task automatic send_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                           logic signed [DIST_W-1:0] distance);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    action         <= act;
    entry_id       <= id;
    entry_distance <= distance;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_config(logic [KEEP_W-1:0] keep, bit asc, logic [CFG_IDX_W-1:0] spare);
    drain();
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_write(REG_KEEP_COUNT, keep);
    cfg_write(REG_ASCENDING, {5'($urandom_range(0, 31)), asc});
    cfg_write(spare, 6'($urandom_range(0, 63)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_asc = asc;
  endtask

  task automatic run_sequence(int ns, int nt, bit ordered);
    dist_q_t sd;
    dist_q_t td;
    int      i;
    int      j;
    sd = sorted_dists(ns, cur_asc, ordered);
    td = sorted_dists(nt, cur_asc, ordered);
    i = 0;
    j = 0;
    while (i < ns || j < nt) begin
      if ($urandom_range(0, 11) == 0) send_item(ACT_UNUSED, pick_id(), pick_distance());
      if (j >= nt || (i < ns && $urandom_range(0, 1) == 1)) begin
        send_item(ACT_LOAD_SRC, pick_id(), sd[i]);
        i++;
      end else begin
        send_item(ACT_LOAD_TGT, pick_id(), td[j]);
        j++;
      end
    end
    send_item(ACT_MERGE, pick_id(), pick_distance());
  endtask

  task automatic directed_items();
    send_item(ACT_MERGE, '0, '0);                      // both lists empty
    send_item(ACT_UNUSED, '1, '1);
    send_item(ACT_LOAD_SRC, 63'h7FFF_FFFF_FFFF_FFFF, 32'sh8000_0000);
    send_item(ACT_LOAD_SRC, '0, -32'sd1);
    send_item(ACT_LOAD_SRC, 63'h5555_5555_5555_5555, 32'sh7FFF_FFFF);
    send_item(ACT_MERGE, '1, '1);                      // empty target takes source
    send_item(ACT_MERGE, '0, '0);                      // empty source keeps target
    send_item(ACT_LOAD_SRC, 63'd1, 32'sh8000_0000);    // ties go to source
    send_item(ACT_LOAD_SRC, 63'd2, '0);
    send_item(ACT_LOAD_SRC, 63'd3, 32'sh7FFF_FFFF);
    send_item(ACT_MERGE, 63'h2AAA_AAAA_AAAA_AAAA, 32'sh5555_5555);
    send_item(ACT_LOAD_TGT, 63'h2AAA_AAAA_AAAA_AAAA, 32'sh7FFF_FFFF);
    send_item(ACT_LOAD_SRC, 63'd4, 32'sd5);
    send_item(ACT_MERGE, '1, '1);
    send_item(ACT_MERGE, '0, 32'sh8000_0000);
    send_item(ACT_UNUSED, '0, '0);
  endtask

  initial begin
    logic [KEEP_W-1:0] keep_tab[NUM_PHASES];
    bit                asc_tab[NUM_PHASES];
    int                phase_start;
    int                ns;
    int                nt;
    keep_tab = '{6'd1, 6'd0, 6'd63, 6'd7, 6'd32, 6'd3};
    asc_tab  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    sb = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_LOAD_SRC;
    entry_id       = '0;
    entry_distance = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_KEEP_COUNT;
    cfg_data       = '0;
    no_idle        = 1'b0;
    cur_asc        = 1'b1;
    result_taken   = 1'b0;
    results_seen   = 0;
    items_sent     = 0;
    cycle_count    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_config(KEEP_RESET, 1'b1, REG_SPARE_A);
    directed_items();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(keep_tab[p], asc_tab[p], (p % 2 == 0) ? REG_SPARE_B : REG_SPARE_A);
      no_idle = (p == 3);
      phase_start = items_sent;
      if (p == 0) begin
        // overflow both lists once
        run_sequence(0, LIST_DEPTH + 1, 1'b1);
        run_sequence(LIST_DEPTH + 1, 0, 1'b1);
      end
      run_sequence($urandom_range(1, 6), $urandom_range(0, 2), 1'b1);
      drain();
      while (items_sent - phase_start < PHASE_ITEMS) begin
        ns = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        nt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        run_sequence(ns, nt, $urandom_range(0, 7) != 0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() > 0) sb.report($sformatf("%0d items never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
